[hdl/spk_pkg.sv]
// Shared constants, register indexes and widths for the speed PI controller.
package spk_pkg;

  // Output duty limit and the saturation applied to the 10-bit duty fields.
  localparam int unsigned DUTY_MAX   = 1023;
  localparam int unsigned DUTY_W     = 10;
  localparam logic [DUTY_W-1:0] OUT_LIMIT =
      DUTY_W'((DUTY_MAX < 1023) ? DUTY_MAX : 1023);

  // Field widths.
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned KICK_W     = 10;
  localparam int unsigned TGT_IN_W   = 15;
  localparam int unsigned DELTA_W    = 12;
  localparam int unsigned DRIVE_W    = 11;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;

  // Datapath widths.
  localparam int unsigned MUL_A_W    = 30;
  localparam int unsigned MUL_B_W    = 17;
  localparam int unsigned MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned TGT_W      = 27;
  localparam int unsigned MEAS_W     = 28;
  localparam int unsigned ERR_W      = 29;
  localparam int unsigned INTEG_W    = 28;
  localparam int unsigned INTEG_FRAC = 11;
  localparam int unsigned SUM_FRAC   = 24;
  localparam int unsigned SUM_W      = 48;

  localparam logic signed [SUM_W-1:0] INT_LIM = SUM_W'(DUTY_MAX) <<< INTEG_FRAC;
  localparam logic signed [SUM_W-1:0] SUM_LIM = SUM_W'(DUTY_MAX) <<< SUM_FRAC;
  localparam logic signed [SUM_W-1:0] INC_ROUND =
      SUM_W'(1) <<< (SUM_FRAC - INTEG_FRAC - 1);
  localparam logic [SUM_W-1:0] MAG_ROUND = SUM_W'(1) << (SUM_FRAC - 1);

  // One rpm and the breakaway speed, both in Q8.
  localparam logic signed [TGT_W-1:0]  ONE_RPM_Q8   = TGT_W'(256);
  localparam logic signed [MEAS_W-1:0] BREAKAWAY_Q8 = MEAS_W'(50 * 256);

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_GEAR_RATIO  = 3'd0;
  localparam logic [IDX_W-1:0] REG_RPM_PER_CNT = 3'd1;
  localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN  = 3'd3;
  localparam logic [IDX_W-1:0] REG_FF_GAIN     = 3'd4;
  localparam logic [IDX_W-1:0] REG_KICK_START  = 3'd5;
  localparam logic [IDX_W-1:0] REG_KICK_STEP   = 3'd6;
  localparam logic [IDX_W-1:0] REG_KICK_CEIL   = 3'd7;

  // Register reset values.
  localparam logic [CFG_W-1:0]  GEAR_RATIO_RST  = 16'd33536;
  localparam logic [CFG_W-1:0]  RPM_PER_CNT_RST = 16'd12000;
  localparam logic [CFG_W-1:0]  PROP_GAIN_RST   = 16'd1966;
  localparam logic [CFG_W-1:0]  INTEG_GAIN_RST  = 16'd131;
  localparam logic [CFG_W-1:0]  FF_GAIN_RST     = 16'd7449;
  localparam logic [KICK_W-1:0] KICK_START_RST  = 10'd400;
  localparam logic [KICK_W-1:0] KICK_STEP_RST   = 10'd30;
  localparam logic [KICK_W-1:0] KICK_CEIL_RST   = 10'd850;

endpackage

[hdl/speed_pi_with_breakaway_kick.sv]
// Speed PI controller with feedforward and breakaway kick, on one shared multiplier.
//
//   channel   dir  handshake                  payload (low bit up)
//   s_axis    in   s_axis_tvalid/tready       enable, target_speed_q4, encoder_delta
//   m_axis    out  m_axis_tvalid/tready       duty_forward, duty_reverse,
//                                             drive_signed, stalled_flag
//   cfg       in   cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// An enabled tick runs from acceptance to the result register in this order: five
// products go one after another through the single 30x17 signed multiplier,
// followed by integrator, sum, kick and rounding steps. A disabled tick goes
// straight to the output step. A new word is taken only while the sequencer is idle.
// Reset loads the register defaults, clears the integrator and arms the kick
// at kick_start. A stalled output holds its word; the sequencer finishes the
// next tick and waits in its last step until the output register is free.
module speed_pi_with_breakaway_kick (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // enable[0], target_speed_q4[15:1], encoder_delta[27:16], zero fill
  input  logic [spk_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // duty_forward[9:0], duty_reverse[19:10], drive_signed[30:20], stalled_flag[31]
  output logic [spk_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we_i,
  input  logic [spk_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [spk_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import spk_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TGT, ST_MEAS, ST_ERR, ST_PROP,
    ST_INTG, ST_UPD, ST_SUM, ST_KICK, ST_OUT
  } state_e;

  // Configuration registers.
  logic [CFG_W-1:0]  gear_q, rpm_q, pgain_q, igain_q, ffgain_q;
  logic [KICK_W-1:0] kick_start_q, kick_step_q, kick_ceil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_q       <= GEAR_RATIO_RST;
      rpm_q        <= RPM_PER_CNT_RST;
      pgain_q      <= PROP_GAIN_RST;
      igain_q      <= INTEG_GAIN_RST;
      ffgain_q     <= FF_GAIN_RST;
      kick_start_q <= KICK_START_RST;
      kick_step_q  <= KICK_STEP_RST;
      kick_ceil_q  <= KICK_CEIL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GEAR_RATIO:  gear_q       <= cfg_wdata_i;
        REG_RPM_PER_CNT: rpm_q        <= cfg_wdata_i;
        REG_PROP_GAIN:   pgain_q      <= cfg_wdata_i;
        REG_INTEG_GAIN:  igain_q      <= cfg_wdata_i;
        REG_FF_GAIN:     ffgain_q     <= cfg_wdata_i;
        REG_KICK_START:  kick_start_q <= cfg_wdata_i[KICK_W-1:0];
        REG_KICK_STEP:   kick_step_q  <= cfg_wdata_i[KICK_W-1:0];
        REG_KICK_CEIL:   kick_ceil_q  <= cfg_wdata_i[KICK_W-1:0];
        default: ;
      endcase
    end
  end

  state_e state_q;

  // Latched tick inputs.
  logic                      en_q;
  logic signed [TGT_IN_W-1:0] tq4_q;
  logic signed [DELTA_W-1:0]  delta_q;

  // Datapath registers.
  logic signed [MUL_P_W-1:0] prod_q;
  logic signed [TGT_W-1:0]   tgt_q;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [SUM_W-1:0]   acc_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic [KICK_W-1:0]         kick_q;
  logic                      stalled_q;
  logic                      neg_q;
  logic [SUM_W-1:0]          mag_q;

  logic [OUT_DATA_W-1:0] m_tdata_q;
  logic                  m_tvalid_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tvalid = m_tvalid_q;

  // Shared multiplier: operand selection per sequencer step.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  always_comb begin
    case (state_q)
      ST_TGT: begin
        mul_a = MUL_A_W'(tq4_q);
        mul_b = $signed({1'b0, gear_q});
      end
      ST_MEAS: begin
        mul_a = MUL_A_W'(delta_q);
        mul_b = $signed({1'b0, rpm_q});
      end
      ST_ERR: begin
        mul_a = MUL_A_W'(tgt_q);
        mul_b = $signed({1'b0, ffgain_q});
      end
      ST_PROP: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = $signed({1'b0, pgain_q});
      end
      ST_INTG: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = $signed({1'b0, igain_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Step-local arithmetic.
  logic signed [MEAS_W-1:0] meas_w;
  logic                     commanded_w, slow_w;
  logic signed [SUM_W-1:0]  inc_w, isum_w, ssum_w;
  logic [KICK_W:0]          kick_inc_w;
  logic [KICK_W-1:0]        kick_next_w;
  logic [SUM_W-1:0]         abs_acc_w, kick_full_w, rnd_w;
  logic [SUM_W-SUM_FRAC-1:0] mag_wide_w;
  logic [DUTY_W-1:0]        mag_out_w;
  logic [DRIVE_W-1:0]       drive_w;

  always_comb begin
    meas_w      = prod_q[MEAS_W-1:0];
    commanded_w = (tgt_q > ONE_RPM_Q8) || (tgt_q < -ONE_RPM_Q8);
    slow_w      = (meas_w < BREAKAWAY_Q8) && (meas_w > -BREAKAWAY_Q8);

    // Integrator increment, Q24 rounded half up to Q11.
    inc_w  = (SUM_W'(prod_q) + INC_ROUND) >>> (SUM_FRAC - INTEG_FRAC);
    isum_w = SUM_W'(integ_q) + inc_w;

    ssum_w = acc_q + (SUM_W'(integ_q) <<< (SUM_FRAC - INTEG_FRAC));

    kick_inc_w  = {1'b0, kick_q} + {1'b0, kick_step_q};
    kick_next_w = (kick_inc_w > {1'b0, kick_ceil_q}) ? kick_ceil_q
                                                     : kick_inc_w[KICK_W-1:0];

    abs_acc_w   = (acc_q < 0) ? SUM_W'(-acc_q) : SUM_W'(acc_q);
    kick_full_w = SUM_W'({kick_q, {SUM_FRAC{1'b0}}});

    rnd_w      = mag_q + MAG_ROUND;
    mag_wide_w = rnd_w[SUM_W-1:SUM_FRAC];
    mag_out_w  = (mag_wide_w > (SUM_W-SUM_FRAC)'(OUT_LIMIT)) ? OUT_LIMIT
                                                            : mag_wide_w[DUTY_W-1:0];
    drive_w    = neg_q ? (DRIVE_W'(0) - {1'b0, mag_out_w}) : {1'b0, mag_out_w};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      integ_q    <= '0;
      kick_q     <= KICK_START_RST;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      en_q       <= 1'b0;
      tq4_q      <= '0;
      delta_q    <= '0;
      prod_q     <= '0;
      tgt_q      <= '0;
      err_q      <= '0;
      acc_q      <= '0;
      stalled_q  <= 1'b0;
      neg_q      <= 1'b0;
      mag_q      <= '0;
    end else begin
      // Drop the result word once taken, unless the last step loads a new one.
      if (m_tvalid_q && m_axis_tready && (state_q != ST_OUT)) begin
        m_tvalid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            en_q    <= s_axis_tdata[0];
            tq4_q   <= s_axis_tdata[TGT_IN_W:1];
            delta_q <= s_axis_tdata[TGT_IN_W+DELTA_W:TGT_IN_W+1];
            state_q <= ST_TGT;
          end
        end
        ST_TGT: begin
          if (!en_q) begin
            // Coast: clear the loop and return an all-zero word.
            integ_q   <= '0;
            kick_q    <= kick_start_q;
            stalled_q <= 1'b0;
            neg_q     <= 1'b0;
            mag_q     <= '0;
            state_q   <= ST_OUT;
          end else begin
            prod_q  <= mul_p;
            state_q <= ST_MEAS;
          end
        end
        ST_MEAS: begin
          // Target motor rpm Q8: floor of the Q12 product.
          tgt_q   <= prod_q[TGT_W+3:4];
          prod_q  <= mul_p;
          state_q <= ST_ERR;
        end
        ST_ERR: begin
          err_q     <= ERR_W'(tgt_q) - ERR_W'(meas_w);
          stalled_q <= commanded_w && slow_w;
          prod_q    <= mul_p;
          state_q   <= ST_PROP;
        end
        ST_PROP: begin
          acc_q   <= SUM_W'(prod_q);
          prod_q  <= mul_p;
          state_q <= ST_INTG;
        end
        ST_INTG: begin
          acc_q   <= acc_q + SUM_W'(prod_q);
          prod_q  <= mul_p;
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          // Freeze the integrator while stalled.
          if (!stalled_q) begin
            if (isum_w > INT_LIM) begin
              integ_q <= INTEG_W'(INT_LIM);
            end else if (isum_w < -INT_LIM) begin
              integ_q <= INTEG_W'(-INT_LIM);
            end else begin
              integ_q <= isum_w[INTEG_W-1:0];
            end
          end
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          if (ssum_w > SUM_LIM) begin
            acc_q <= SUM_LIM;
          end else if (ssum_w < -SUM_LIM) begin
            acc_q <= -SUM_LIM;
          end else begin
            acc_q <= ssum_w;
          end
          // Escalate the kick while stalled, re-arm it otherwise.
          kick_q  <= stalled_q ? kick_next_w : kick_start_q;
          state_q <= ST_KICK;
        end
        ST_KICK: begin
          if (stalled_q && (abs_acc_w < kick_full_w)) begin
            neg_q <= (tgt_q < 0);
            mag_q <= kick_full_w;
          end else begin
            neg_q <= (acc_q < 0);
            mag_q <= abs_acc_w;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // Hold until the output register is free.
          if (!m_tvalid_q || m_axis_tready) begin
            m_tdata_q  <= {stalled_q, drive_w,
                           neg_q ? mag_out_w : DUTY_W'(0),
                           neg_q ? DUTY_W'(0) : mag_out_w};
            m_tvalid_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[tb/sv/speed_pi_with_breakaway_kick_tb.sv]
// Self-checking testbench for the speed PI controller with breakaway kick.
module speed_pi_with_breakaway_kick_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spk_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int TICKS_PER_PHASE = 212;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int SETTLE_CYCLES   = 30;
  localparam int MAX_PRINTS      = 40;

  // One input word, laid out as s_axis_tdata (last field in the low bits).
  typedef struct packed {
    logic [3:0]         pad;
    logic signed [11:0] delta;
    logic signed [14:0] target;
    logic               enable;
  } tick_t;

  // One output word, laid out as m_axis_tdata.
  typedef struct packed {
    logic               stalled;
    logic signed [10:0] drive;
    logic [9:0]         rev;
    logic [9:0]         fwd;
  } duty_word_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [IDX_W-1:0]      cfg_idx_i     = '0;
  logic [CFG_W-1:0]      cfg_wdata_i   = '0;

  speed_pi_with_breakaway_kick dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Pending ticks for the driver and duty words still owed by the block.
  tick_t      tick_q[$];
  duty_word_t duty_q[$];

  // Shadow of the register file and of the loop state.
  logic [15:0] cfg_shadow [8];
  longint      integ_acc;
  logic [9:0]  kick_lvl;

  int err_count    = 0;
  int ticks_taken  = 0;
  int words_seen   = 0;
  int stall_words  = 0;
  int kick_words   = 0;
  int cycle_cnt    = 0;

  int  send_gap   = 0;
  int  recv_stall = 0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_PRINTS)
      $display("MISMATCH tick %0d: %s got %0d want %0d", words_seen, what, got, want);
    err_count++;
  endtask

  // Work out the duty word for one accepted tick and advance the loop state.
  task automatic predict_tick(input tick_t t);
    longint tq, dl, gear, rpc, kp, ki, kff, tgt, meas, err, sum, ilim, slim, klim, mag;
    logic [10:0] kn;
    logic commanded, stall, neg;
    duty_word_t w;
    w = '0;
    if (!t.enable) begin
      // Coast: drop the integrator and re-arm the kick.
      integ_acc = 0;
      kick_lvl  = cfg_shadow[REG_KICK_START][9:0];
    end else begin
      tq   = t.target;
      dl   = t.delta;
      gear = cfg_shadow[REG_GEAR_RATIO];
      rpc  = cfg_shadow[REG_RPM_PER_CNT];
      kp   = cfg_shadow[REG_PROP_GAIN];
      ki   = cfg_shadow[REG_INTEG_GAIN];
      kff  = cfg_shadow[REG_FF_GAIN];
      ilim = longint'(DUTY_MAX) <<< INTEG_FRAC;
      slim = longint'(DUTY_MAX) <<< SUM_FRAC;

      tgt  = (tq * gear) >>> 4;
      meas = dl * rpc;
      err  = tgt - meas;

      commanded = (tgt > 256) || (tgt < -256);
      stall     = commanded && (meas < 50 * 256) && (meas > -50 * 256);

      // Freeze the integrator while stalled, else add the rounded increment.
      if (!stall) begin
        integ_acc = integ_acc + ((err * ki + (64'sd1 <<< 12)) >>> 13);
        if (integ_acc > ilim)  integ_acc = ilim;
        if (integ_acc < -ilim) integ_acc = -ilim;
      end

      sum = tgt * kff + err * kp + (integ_acc <<< (SUM_FRAC - INTEG_FRAC));
      if (sum > slim)  sum = slim;
      if (sum < -slim) sum = -slim;

      // Escalate the kick on a stall and hold it as the minimum magnitude.
      if (stall) begin
        kn = {1'b0, kick_lvl} + {1'b0, cfg_shadow[REG_KICK_STEP][9:0]};
        if (kn > {1'b0, cfg_shadow[REG_KICK_CEIL][9:0]})
          kn = {1'b0, cfg_shadow[REG_KICK_CEIL][9:0]};
        kick_lvl = kn[9:0];
        klim = longint'(kick_lvl) <<< SUM_FRAC;
        if (((sum < 0) ? -sum : sum) < klim) begin
          sum = (tgt >= 0) ? klim : -klim;
          kick_words++;
        end
      end else begin
        kick_lvl = cfg_shadow[REG_KICK_START][9:0];
      end

      neg = sum < 0;
      mag = (((sum < 0) ? -sum : sum) + (64'sd1 <<< (SUM_FRAC - 1))) >>> SUM_FRAC;
      if (mag > longint'(OUT_LIMIT)) mag = OUT_LIMIT;

      w.fwd     = neg ? 10'd0 : mag[9:0];
      w.rev     = neg ? mag[9:0] : 10'd0;
      w.drive   = neg ? -mag[10:0] : mag[10:0];
      w.stalled = stall;
    end
    duty_q.push_back(w);
  endtask

  task automatic push_tick(input bit en, input int tq, input int dl);
    tick_t t;
    t.pad    = '0;
    t.enable = en;
    t.target = tq[14:0];
    t.delta  = dl[11:0];
    tick_q.push_back(t);
  endtask

  // Extremes, coasting, stalls in both directions and kick growth.
  task automatic push_directed();
    int i;
    push_tick(1'b0, 16383, -2048);
    push_tick(1'b0, -16384, 2047);
    push_tick(1'b1, 0, 0);
    for (i = 0; i < 6; i++) push_tick(1'b1, 1, 0);
    for (i = 0; i < 3; i++) push_tick(1'b1, -1, 0);
    push_tick(1'b1, 16383, 0);
    push_tick(1'b1, -16384, 0);
    push_tick(1'b1, 16383, 2047);
    push_tick(1'b1, -16384, -2048);
    push_tick(1'b1, 16383, -2048);
    push_tick(1'b1, -16384, 2047);
    push_tick(1'b1, 0, 2047);
    push_tick(1'b1, 0, -2048);
    push_tick(1'b1, 6, 1);
    push_tick(1'b1, 0, 1);
    push_tick(1'b0, 0, 0);
  endtask

  // Runs of enabled ticks at a held target with varied feedback, some noise words and coast ticks.
  task automatic push_random(input int count);
    int n, k, run_len, tmode, dmode, tq;
    longint tgt, dd;
    tick_t t;
    n = 0;
    while (n < count) begin
      run_len = $urandom_range(1, 30);
      tmode   = $urandom_range(0, 3);
      case (tmode)
        0:       tq = int'($urandom_range(0, 32767)) - 16384;
        1:       tq = int'($urandom_range(0, 8)) - 4;
        2:       tq = int'($urandom_range(0, 2000)) - 1000;
        default: tq = int'($urandom_range(0, 200)) - 100;
      endcase
      for (k = 0; k < run_len && n < count; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          t = $urandom;
          t.pad = '0;
          tick_q.push_back(t);
        end else begin
          dmode = $urandom_range(0, 3);
          case (dmode)
            0: dd = longint'(int'($urandom_range(0, 4095)) - 2048);
            1: dd = longint'(int'($urandom_range(0, 4)) - 2);
            default: begin
              // Track the target so the loop sits near its operating point.
              tgt = (longint'(tq) * longint'(cfg_shadow[REG_GEAR_RATIO])) >>> 4;
              dd  = (cfg_shadow[REG_RPM_PER_CNT] == 0) ? 0 :
                    tgt / longint'(cfg_shadow[REG_RPM_PER_CNT]);
              dd  = dd + longint'(int'($urandom_range(0, 6)) - 3);
              if (dd > 2047)  dd = 2047;
              if (dd < -2048) dd = -2048;
            end
          endcase
          push_tick(1'b1, tq, int'(dd));
        end
        n++;
      end
      if ($urandom_range(0, 2) == 0) begin
        push_tick(1'b0, int'($urandom_range(0, 32767)), int'($urandom_range(0, 4095)));
        n++;
      end
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    cfg_shadow[idx] = (idx >= REG_KICK_START) ? {6'd0, val[9:0]} : val;
  endtask

  // Pick the register set for a phase: all ones, all zeros, a corner, or random.
  task automatic load_phase_cfg(input int ph);
    logic [15:0] v [8];
    int i;
    case (ph)
      1: for (i = 0; i < 8; i++) v[i] = 16'hFFFF;
      2: for (i = 0; i < 8; i++) v[i] = 16'h0000;
      3: begin
        v[REG_GEAR_RATIO]  = 16'd1;
        v[REG_RPM_PER_CNT] = 16'd1;
        v[REG_PROP_GAIN]   = 16'd1;
        v[REG_INTEG_GAIN]  = 16'd1;
        v[REG_FF_GAIN]     = 16'd1;
        v[REG_KICK_START]  = 16'd1023;
        v[REG_KICK_STEP]   = 16'd1023;
        v[REG_KICK_CEIL]   = 16'd0;
      end
      default: begin
        v[REG_GEAR_RATIO]  = $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                 : $urandom_range(1000, 40000);
        v[REG_RPM_PER_CNT] = $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                 : $urandom_range(100, 20000);
        v[REG_PROP_GAIN]   = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 6000);
        v[REG_INTEG_GAIN]  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 1000);
        v[REG_FF_GAIN]     = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 12000);
        v[REG_KICK_START]  = $urandom_range(0, 1023);
        v[REG_KICK_STEP]   = $urandom_range(0, 1023);
        v[REG_KICK_CEIL]   = $urandom_range(0, 1023);
      end
    endcase
    for (i = 0; i < 8; i++) write_reg(IDX_W'(i), v[i]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Driver: present the next pending word, hold it until taken, then idle a random gap, or none in a burst.
  always @(posedge clk_i) begin : drive_ticks
    tick_t nxt;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (tick_q.size() != 0) begin
          nxt = tick_q.pop_front();
          s_axis_tdata  <= nxt;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
          send_gap <= send_burst ? 0 : $urandom_range(0, 10);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output word against the oldest prediction, stall the
  // output at random, and predict every input word the block takes.
  always @(posedge clk_i) begin : watch_ports
    duty_word_t got, want;
    int n;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        words_seen++;
        if (got.stalled) stall_words++;
        if (duty_q.size() == 0) begin
          report_mismatch("word with no pending tick", int'(got), 0);
        end else begin
          want = duty_q.pop_front();
          if (got.fwd !== want.fwd)
            report_mismatch("duty_forward", int'(got.fwd), int'(want.fwd));
          if (got.rev !== want.rev)
            report_mismatch("duty_reverse", int'(got.rev), int'(want.rev));
          if (got.drive !== want.drive)
            report_mismatch("drive_signed", int'(got.drive), int'(want.drive));
          if (got.stalled !== want.stalled)
            report_mismatch("stalled_flag", int'(got.stalled), int'(want.stalled));
        end
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        n = recv_burst ? 0 : $urandom_range(0, 10);
        recv_stall    <= n;
        m_axis_tready <= (n == 0);
      end else if (recv_stall != 0) begin
        recv_stall    <= recv_stall - 1;
        m_axis_tready <= (recv_stall == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tick(s_axis_tdata);
        ticks_taken++;
      end
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("speed_pi_with_breakaway_kick test failed");
      $finish;
    end
  end

  // Sequencer: reset, then phases of stimulus with register writes in between.
  initial begin : run_phases
    int ph;
    cfg_shadow[REG_GEAR_RATIO]  = GEAR_RATIO_RST;
    cfg_shadow[REG_RPM_PER_CNT] = RPM_PER_CNT_RST;
    cfg_shadow[REG_PROP_GAIN]   = PROP_GAIN_RST;
    cfg_shadow[REG_INTEG_GAIN]  = INTEG_GAIN_RST;
    cfg_shadow[REG_FF_GAIN]     = FF_GAIN_RST;
    cfg_shadow[REG_KICK_START]  = {6'd0, KICK_START_RST};
    cfg_shadow[REG_KICK_STEP]   = {6'd0, KICK_STEP_RST};
    cfg_shadow[REG_KICK_CEIL]   = {6'd0, KICK_CEIL_RST};
    integ_acc = 0;
    kick_lvl  = KICK_START_RST;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        // Run first on reset values.
        push_directed();
      end else begin
        // Drain the block completely before touching any register.
        while (!(tick_q.size() == 0 && !s_axis_tvalid && duty_q.size() == 0))
          @(posedge clk_i);
        repeat (SETTLE_CYCLES) @(posedge clk_i);
        load_phase_cfg(ph);
      end
      push_random(TICKS_PER_PHASE);
    end

    while (!(tick_q.size() == 0 && !s_axis_tvalid && duty_q.size() == 0))
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d ticks over %0d register sets, %0d words checked.",
             ticks_taken, NUM_PHASES, words_seen);
    $display("Stalled words %0d, kick-limited words %0d, mismatches %0d.",
             stall_words, kick_words, err_count);
    if (err_count == 0 && duty_q.size() == 0) begin
      $display("speed_pi_with_breakaway_kick test passed");
    end else begin
      $display("speed_pi_with_breakaway_kick test failed");
    end
    $finish;
  end

endmodule
